### rtl/sklist_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted key list engine.
// Used by the RAM, the sequencer, the top level and the port checker.
package sklist_pkg;
   localparam int DEPTH = 64;
   localparam int KEY_WIDTH = 32;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = IDX_W + 1;

   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_LOOKUP = 3'd2;
   localparam logic [2:0] OP_DRAIN  = 3'd3;
   localparam logic [2:0] OP_SORT   = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_EMPTY     = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_POP_OUT, S_LK_CHK, S_LK_CMP, S_DR_RD, S_DR_OUT,
      S_SORT_START, S_SORT_LOAD, S_SORT_RD, S_SORT_CMP, S_SORT_WEND, S_SORT_DONE
   } state_type;

   typedef struct packed {
      logic                 we;
      logic [IDX_W-1:0]     waddr;
      logic [KEY_WIDTH-1:0] wdata;
      logic                 re;
      logic [IDX_W-1:0]     raddr;
   } mem_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value;
      logic [5:0]  position;
      logic [5:0]  count;
      logic        last;
   } rsp_type;
endpackage

### rtl/sklist_mem.sv
`timescale 1ns / 1ps
// Key store: one write port and one registered read port.
// Depends on sklist_pkg.
module sklist_mem (
   input  logic                            clock,
   input  sklist_pkg::mem_req_type         mem_req,
   output logic [sklist_pkg::KEY_WIDTH-1:0] rdata
);
   logic [sklist_pkg::KEY_WIDTH-1:0] mem [sklist_pkg::DEPTH];
   logic [sklist_pkg::KEY_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

### rtl/sklist_seq.sv
`timescale 1ns / 1ps
// Operation sequencer with the shared key comparator.
// Depends on sklist_pkg; drives the key store through sklist_mem.
module sklist_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [2:0]                       req_op,
   input  logic [31:0]                      req_key,
   input  logic                             out_free,
   output logic                             emit_valid,
   output sklist_pkg::rsp_type              emit_data,
   output sklist_pkg::mem_req_type          mem_req,
   input  logic [sklist_pkg::KEY_WIDTH-1:0] rdata
);
   localparam int IW = sklist_pkg::IDX_W;
   localparam int CW = sklist_pkg::CNT_W;
   localparam int KW = sklist_pkg::KEY_WIDTH;

   sklist_pkg::state_type state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [KW-1:0] key_ff, key_in;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [IW-1:0] idx_ff, idx_in, end_ff, end_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [KW-1:0] cur_ff, cur_in;

   logic [KW-1:0] cmp_a, cmp_b;
   logic          cmp_lt, cmp_eq;
   logic [CW-1:0] mid_sum;
   logic [IW-1:0] mid;
   logic          full, empty, one_or_less, lk_last, dr_last;

   assign full    = ({1'b0, tail_ff} + CW'(1)) >= CW'(sklist_pkg::DEPTH);
   assign empty   = head_ff == tail_ff;
   assign one_or_less = ({1'b0, tail_ff} - {1'b0, head_ff}) <= CW'(1);
   assign mid_sum = lo_ff + hi_ff - CW'(1);
   assign mid     = mid_sum[IW:1];
   assign lk_last = lo_ff < hi_ff;
   assign dr_last = (idx_ff + IW'(1)) == tail_ff;

   always_comb begin
      if (state_ff == sklist_pkg::S_LK_CMP) begin
         cmp_a = key_ff;
         cmp_b = rdata;
      end else begin
         cmp_a = rdata;
         cmp_b = cur_ff;
      end
   end
   assign cmp_lt = cmp_a < cmp_b;
   assign cmp_eq = cmp_a == cmp_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sklist_pkg::S_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
      end
      op_ff  <= op_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
      end_ff <= end_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      cur_ff <= cur_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sklist_pkg::S_IDLE:
            if (req_valid) state_in = sklist_pkg::S_DISPATCH;
         sklist_pkg::S_DISPATCH:
            unique case (op_ff)
               sklist_pkg::OP_PUSH:
                  if (out_free) state_in = sklist_pkg::S_IDLE;
               sklist_pkg::OP_POP:
                  if (!empty) state_in = sklist_pkg::S_POP_OUT;
                  else if (out_free) state_in = sklist_pkg::S_IDLE;
               sklist_pkg::OP_LOOKUP: state_in = sklist_pkg::S_LK_CHK;
               sklist_pkg::OP_DRAIN:
                  if (!empty) state_in = sklist_pkg::S_DR_RD;
                  else if (out_free) state_in = sklist_pkg::S_IDLE;
               sklist_pkg::OP_SORT:
                  if (one_or_less) state_in = sklist_pkg::S_SORT_DONE;
                  else state_in = sklist_pkg::S_SORT_START;
               default: state_in = sklist_pkg::S_IDLE;
            endcase
         sklist_pkg::S_POP_OUT:
            if (out_free) state_in = sklist_pkg::S_IDLE;
         sklist_pkg::S_LK_CHK:
            if (lk_last) state_in = sklist_pkg::S_LK_CMP;
            else if (out_free) state_in = sklist_pkg::S_IDLE;
         sklist_pkg::S_LK_CMP:
            if (!cmp_eq) state_in = sklist_pkg::S_LK_CHK;
            else if (out_free) state_in = sklist_pkg::S_IDLE;
         sklist_pkg::S_DR_RD: state_in = sklist_pkg::S_DR_OUT;
         sklist_pkg::S_DR_OUT:
            if (out_free) state_in = dr_last ? sklist_pkg::S_IDLE : sklist_pkg::S_DR_RD;
         sklist_pkg::S_SORT_START: state_in = sklist_pkg::S_SORT_LOAD;
         sklist_pkg::S_SORT_LOAD:  state_in = sklist_pkg::S_SORT_RD;
         sklist_pkg::S_SORT_RD:    state_in = sklist_pkg::S_SORT_CMP;
         sklist_pkg::S_SORT_CMP:
            state_in = (idx_ff == end_ff) ? sklist_pkg::S_SORT_WEND : sklist_pkg::S_SORT_RD;
         sklist_pkg::S_SORT_WEND:
            state_in = (end_ff == head_ff + IW'(1)) ? sklist_pkg::S_SORT_DONE
                                                    : sklist_pkg::S_SORT_START;
         sklist_pkg::S_SORT_DONE:
            if (out_free) state_in = sklist_pkg::S_IDLE;
         default: state_in = sklist_pkg::S_IDLE;
      endcase
   end

   // datapath registers
   always_comb begin
      op_in   = op_ff;
      key_in  = key_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      idx_in  = idx_ff;
      end_in  = end_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      cur_in  = cur_ff;
      case (state_ff)
         sklist_pkg::S_IDLE:
            if (req_valid) begin
               op_in  = req_op;
               key_in = KW'(req_key);
            end
         sklist_pkg::S_DISPATCH:
            case (op_ff)
               sklist_pkg::OP_PUSH:
                  if (out_free && !full) tail_in = tail_ff + IW'(1);
               sklist_pkg::OP_LOOKUP: begin
                  lo_in = {1'b0, head_ff};
                  hi_in = {1'b0, tail_ff};
               end
               sklist_pkg::OP_DRAIN:
                  if (!empty) idx_in = head_ff;
                  else if (out_free) begin
                     head_in = '0;
                     tail_in = '0;
                  end
               sklist_pkg::OP_SORT: end_in = tail_ff - IW'(1);
               default: ;
            endcase
         sklist_pkg::S_POP_OUT:
            if (out_free) head_in = head_ff + IW'(1);
         sklist_pkg::S_LK_CHK: idx_in = mid;
         sklist_pkg::S_LK_CMP:
            if (!cmp_eq) begin
               if (cmp_lt) hi_in = {1'b0, idx_ff};
               else lo_in = {1'b0, idx_ff} + CW'(1);
            end
         sklist_pkg::S_DR_OUT:
            if (out_free) begin
               if (dr_last) begin
                  head_in = '0;
                  tail_in = '0;
               end else idx_in = idx_ff + IW'(1);
            end
         sklist_pkg::S_SORT_LOAD: begin
            cur_in = rdata;
            idx_in = head_ff + IW'(1);
         end
         sklist_pkg::S_SORT_CMP: begin
            if (!cmp_lt) cur_in = rdata;
            idx_in = idx_ff + IW'(1);
         end
         sklist_pkg::S_SORT_WEND: end_in = end_ff - IW'(1);
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = state_ff == sklist_pkg::S_IDLE;
      emit_valid = 1'b0;
      emit_data  = '0;
      emit_data.last = 1'b1;
      mem_req    = '0;
      unique case (state_ff)
         sklist_pkg::S_DISPATCH:
            unique case (op_ff)
               sklist_pkg::OP_PUSH: begin
                  emit_valid = 1'b1;
                  if (full) emit_data.status = sklist_pkg::ST_FULL;
                  else begin
                     emit_data.position = 6'(tail_ff + IW'(1));
                     mem_req.we    = out_free;
                     mem_req.waddr = tail_ff;
                     mem_req.wdata = key_ff;
                  end
               end
               sklist_pkg::OP_POP:
                  if (empty) begin
                     emit_valid = 1'b1;
                     emit_data.status = sklist_pkg::ST_EMPTY;
                  end else begin
                     mem_req.re    = 1'b1;
                     mem_req.raddr = head_ff;
                  end
               sklist_pkg::OP_DRAIN:
                  if (empty) begin
                     emit_valid = 1'b1;
                     emit_data.status = sklist_pkg::ST_EMPTY;
                  end
               default: ;
            endcase
         sklist_pkg::S_POP_OUT: begin
            emit_valid = 1'b1;
            emit_data.value = 32'(rdata);
         end
         sklist_pkg::S_LK_CHK:
            if (lk_last) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = mid;
            end else begin
               emit_valid = 1'b1;
               emit_data.status = sklist_pkg::ST_NOT_FOUND;
            end
         sklist_pkg::S_LK_CMP:
            if (cmp_eq) begin
               emit_valid = 1'b1;
               emit_data.position = 6'(idx_ff);
            end
         sklist_pkg::S_DR_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_ff;
         end
         sklist_pkg::S_DR_OUT: begin
            emit_valid = 1'b1;
            emit_data.value    = 32'(rdata);
            emit_data.position = 6'(idx_ff);
            emit_data.count    = 6'(tail_ff - head_ff);
            emit_data.last     = dr_last;
         end
         sklist_pkg::S_SORT_START: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = head_ff;
         end
         sklist_pkg::S_SORT_RD: begin
            mem_req.re    = 1'b1;
            mem_req.raddr = idx_ff;
         end
         sklist_pkg::S_SORT_CMP: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff - IW'(1);
            mem_req.wdata = cmp_lt ? rdata : cur_ff;
         end
         sklist_pkg::S_SORT_WEND: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = end_ff;
            mem_req.wdata = cur_ff;
         end
         sklist_pkg::S_SORT_DONE: emit_valid = 1'b1;
         default: ;
      endcase
   end
endmodule

### rtl/sorted_key_list_engine.sv
`timescale 1ns / 1ps
// Sorted key list engine top level: sequencer, key store, result register.
// Lookup is a binary search of up to 6 steps; drain returns one result per entry, in order;
// sort is a bubble sort over the stored entries.
// One transaction in flight; the sequencer shares a single key comparator.
// Synchronous active-high reset empties the list; stored keys are not cleared.
module sorted_key_list_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_key,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_value,
   output logic [5:0]  rsp_position,
   output logic [5:0]  rsp_count,
   output logic        rsp_last
);
   sklist_pkg::mem_req_type          mem_req;
   logic [sklist_pkg::KEY_WIDTH-1:0] rdata;
   sklist_pkg::rsp_type              emit_data, rsp_ff;
   logic                             emit_valid, rsp_valid_ff, out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   sklist_seq u_seq (
      .clock, .reset, .req_valid, .req_ready, .req_op, .req_key,
      .out_free, .emit_valid, .emit_data, .mem_req, .rdata
   );

   sklist_mem u_mem (.clock, .mem_req, .rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit_valid;
      end
      if (out_free && emit_valid) begin
         rsp_ff <= emit_data;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_ff.status;
   assign rsp_value    = rsp_ff.value;
   assign rsp_position = rsp_ff.position;
   assign rsp_count    = rsp_ff.count;
   assign rsp_last     = rsp_ff.last;
endmodule

### rtl/sklist_check.sv
`timescale 1ns / 1ps
// Port-level checker for the sorted key list engine, bound to the top level.
// Depends on sklist_pkg.
module sklist_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_value,
   input logic [5:0]  rsp_position,
   input logic        rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status))
      else $error("result dropped or changed while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("new transaction taken while busy");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == sklist_pkg::ST_FULL |-> rsp_position == 6'd0 && rsp_last)
      else $error("full result malformed");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sklist_pkg::ST_OK |-> rsp_value == 32'd0 && rsp_last)
      else $error("failed result carries a value");
endmodule

bind sorted_key_list_engine sklist_check u_check (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
   .rsp_status, .rsp_value, .rsp_position, .rsp_last
);
